// ===== hw/rtl/rclbo_pkg.sv =====
// ----------------------------------------------------------------------------
// rclbo_pkg
// Shared types, constants and arithmetic helpers for the cropped luma and
// detection-box overlay pipeline.
// ----------------------------------------------------------------------------
package rclbo_pkg;

  localparam int FRAME_WIDTH    = 640;
  localparam int CROP_WIDTH     = 480;
  localparam int CROP_HEIGHT    = 480;
  localparam int CROP_OFFSET    = 80;
  localparam int EDGE_THICKNESS = 3;
  localparam int MAX_BOXES      = 6;

  localparam int CX_W = (CROP_WIDTH > 1) ? $clog2(CROP_WIDTH) : 1;
  localparam int CY_W = (CROP_HEIGHT > 1) ? $clog2(CROP_HEIGHT) : 1;

  // frame column arithmetic, wide enough for offset plus crop width
  localparam int COL_W = 14;

  // signed box coordinates: scaled 16-bit values, their sums and differences
  localparam int COORD_W       = 20;
  localparam int BOX_FIELD_W   = 16;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_COUNT_W   = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_BOX_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_A     = 3'd1;

  localparam logic signed [COORD_W-1:0] EDGE_T_S  = COORD_W'(EDGE_THICKNESS);
  localparam logic signed [COORD_W-1:0] CX_MAX_S  = COORD_W'(CROP_WIDTH - 1);
  localparam logic signed [COORD_W-1:0] CY_MAX_S  = COORD_W'(CROP_HEIGHT - 1);

  // luma: (299r + 587g + 114b) / 1000, reciprocal folded into the coefficients
  localparam int LUMA_R     = 299;
  localparam int LUMA_G     = 587;
  localparam int LUMA_B     = 114;
  localparam int LUMA_RECIP = 268436;
  localparam int LUMA_SHIFT = 28;
  localparam int PROD_W     = 37;

  localparam logic [7:0] EDGE_VALUE = 8'hFF;

  typedef struct packed {
    logic [15:0] pixel;
    logic [9:0]  column;
    logic [8:0]  line;
  } in_item_t;

  typedef struct packed {
    logic [7:0] gray;
    logic [8:0] crop_column;
    logic [8:0] crop_line;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic                   en;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_write_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] w;
    logic signed [COORD_W-1:0] h;
  } box_coord_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] y1;
    logic [CX_W-1:0]           hx0;
    logic [CX_W-1:0]           hx1;
    logic [CY_W-1:0]           vy0;
    logic [CY_W-1:0]           vy1;
  } box_geom_t;

  // v * 5 / 2, truncated toward zero
  function automatic logic signed [COORD_W-1:0] scale_coord(logic [BOX_FIELD_W-1:0] v);
    logic signed [COORD_W-1:0] e;
    logic signed [COORD_W-1:0] p;
    e = {{(COORD_W-BOX_FIELD_W){v[BOX_FIELD_W-1]}}, v};
    p = (e <<< 2) + e;
    p = p + {{(COORD_W-1){1'b0}}, p[COORD_W-1]};
    return p >>> 1;
  endfunction

  function automatic logic [CX_W-1:0] clamp_col(logic signed [COORD_W-1:0] v);
    logic [CX_W-1:0] r;
    if (v[COORD_W-1]) begin
      r = '0;
    end else if (v > CX_MAX_S) begin
      r = CX_MAX_S[CX_W-1:0];
    end else begin
      r = v[CX_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [CY_W-1:0] clamp_row(logic signed [COORD_W-1:0] v);
    logic [CY_W-1:0] r;
    if (v[COORD_W-1]) begin
      r = '0;
    end else if (v > CY_MAX_S) begin
      r = CY_MAX_S[CY_W-1:0];
    end else begin
      r = v[CY_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] luma(logic [15:0] pix);
    logic [7:0]        r8;
    logic [7:0]        g8;
    logic [7:0]        b8;
    logic [PROD_W-1:0] p;
    r8 = {pix[15:11], 3'b000};
    g8 = {pix[10:5], 2'b00};
    b8 = {pix[4:0], 3'b000};
    p = PROD_W'(r8) * PROD_W'(LUMA_R * LUMA_RECIP)
      + PROD_W'(g8) * PROD_W'(LUMA_G * LUMA_RECIP)
      + PROD_W'(b8) * PROD_W'(LUMA_B * LUMA_RECIP);
    return p[LUMA_SHIFT +: 8];
  endfunction

endpackage

// ===== hw/rtl/rclbo_box_regs.sv =====
// ----------------------------------------------------------------------------
// rclbo_box_regs
// Configuration registers and per-box edge geometry in crop coordinates.
// ----------------------------------------------------------------------------
module rclbo_box_regs (
  input  logic                                         clk,
  input  logic                                         rst,
  input  rclbo_pkg::cfg_write_t                        cfg_wr,
  output rclbo_pkg::box_geom_t [rclbo_pkg::MAX_BOXES-1:0] geom,
  output logic [rclbo_pkg::MAX_BOXES-1:0]              active
);
  import rclbo_pkg::*;

  logic [CFG_COUNT_W-1:0]        box_count;
  box_coord_t [MAX_BOXES-1:0]    coord;

  // scaled coordinates captured on write
  always_ff @(posedge clk) begin
    if (rst) begin
      box_count <= '0;
      coord     <= '0;
    end else if (cfg_wr.en) begin
      if (cfg_wr.index == REG_BOX_COUNT) begin
        box_count <= cfg_wr.data[CFG_COUNT_W-1:0];
      end
      for (int i = 0; i < MAX_BOXES; i++) begin
        if (cfg_wr.index == REG_BOX_A + CFG_INDEX_W'(i)) begin
          coord[i].x <= scale_coord(cfg_wr.data[15:0]);
          coord[i].y <= scale_coord(cfg_wr.data[31:16]);
          coord[i].w <= scale_coord(cfg_wr.data[47:32]);
          coord[i].h <= scale_coord(cfg_wr.data[63:48]);
        end
      end
    end
  end

  // far edges and clamped spans
  always_ff @(posedge clk) begin
    if (rst) begin
      geom   <= '0;
      active <= '0;
    end else begin
      for (int i = 0; i < MAX_BOXES; i++) begin
        geom[i].x0  <= coord[i].x;
        geom[i].x1  <= coord[i].x + coord[i].w;
        geom[i].y0  <= coord[i].y;
        geom[i].y1  <= coord[i].y + coord[i].h;
        geom[i].hx0 <= clamp_col(coord[i].x);
        geom[i].hx1 <= clamp_col(coord[i].x + coord[i].w);
        geom[i].vy0 <= clamp_row(coord[i].y);
        geom[i].vy1 <= clamp_row(coord[i].y + coord[i].h);
        active[i]   <= box_count > CFG_COUNT_W'(i);
      end
    end
  end

endmodule

// ===== hw/rtl/rclbo_edge_detect.sv =====
// ----------------------------------------------------------------------------
// rclbo_edge_detect
// Tests one crop position against the borders of all active boxes.
// ----------------------------------------------------------------------------
module rclbo_edge_detect (
  input  rclbo_pkg::box_geom_t [rclbo_pkg::MAX_BOXES-1:0] geom,
  input  logic [rclbo_pkg::MAX_BOXES-1:0]              active,
  input  logic [rclbo_pkg::CX_W-1:0]                   cx,
  input  logic [rclbo_pkg::CY_W-1:0]                   cy,
  output logic                                         hit
);
  import rclbo_pkg::*;

  logic signed [COORD_W-1:0] cx_s;
  logic signed [COORD_W-1:0] cy_s;
  logic [MAX_BOXES-1:0]      box_hit;

  // distance within the edge thickness
  function automatic logic near(logic signed [COORD_W-1:0] d);
    return !d[COORD_W-1] && (d < EDGE_T_S);
  endfunction

  always_comb begin
    cx_s = signed'(COORD_W'(cx));
    cy_s = signed'(COORD_W'(cy));
    for (int i = 0; i < MAX_BOXES; i++) begin
      box_hit[i] = active[i] && (
          ((geom[i].hx0 <= cx) && (cx <= geom[i].hx1) &&
           (near(cy_s - geom[i].y0) || near(geom[i].y1 - cy_s))) ||
          ((geom[i].vy0 <= cy) && (cy <= geom[i].vy1) &&
           (near(cx_s - geom[i].x0) || near(geom[i].x1 - cx_s))));
    end
    hit = |box_hit;
  end

endmodule

// ===== hw/rtl/rgb565_crop_luma_box_overlay_core.sv =====
// ----------------------------------------------------------------------------
// rgb565_crop_luma_box_overlay_core
// Center crop of an RGB565 pixel stream, BT.601 luma, detection-box borders.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_item carries one camera pixel with its
// frame column and line. Pixels outside the crop window are consumed and
// give no output transfer. Output channel out_valid/out_ready/out_item
// carries the luma (or 255 on a box border), the crop position and a flag
// on the bottom-right crop pixel.
// Two register stages: input register, then crop test, luma and edge test
// into the output register. An output transfer can follow once the pixel
// has passed both; one pixel per cycle is sustained while out_ready is high.
// A stalled receiver holds the stages in place; while any stage is empty
// the input keeps taking pixels, so in_ready is high whenever out_ready is.
// Configuration port cfg_valid/cfg_ready/cfg_index/cfg_data is always ready;
// box geometry is registered behind the captured coordinates. Reset empties
// the pipeline and clears box_count and all boxes.
// ----------------------------------------------------------------------------
module rgb565_crop_luma_box_overlay_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rclbo_pkg::in_item_t                  in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output rclbo_pkg::out_item_t                 out_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rclbo_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rclbo_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rclbo_pkg::*;

  cfg_write_t                 cfg_wr;
  box_geom_t [MAX_BOXES-1:0]  geom;
  logic [MAX_BOXES-1:0]       active;

  logic                       s0_valid;
  in_item_t                   s0_item;
  logic                       out_free;

  logic [COL_W-1:0]           col_ext;
  logic [COL_W-1:0]           cx_full;
  logic                       keep;
  logic                       hit;
  logic                       at_end;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.en    = cfg_valid & cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  rclbo_box_regs u_box_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg_wr (cfg_wr),
    .geom   (geom),
    .active (active)
  );

  assign out_free = !out_valid || out_ready;
  assign in_ready = !s0_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_item <= in_item;
    end
  end

  // crop window test and position
  always_comb begin
    col_ext = COL_W'(s0_item.column);
    cx_full = col_ext - COL_W'(CROP_OFFSET);
    keep    = (col_ext < COL_W'(FRAME_WIDTH)) &&
              (col_ext >= COL_W'(CROP_OFFSET)) &&
              (col_ext < COL_W'(CROP_OFFSET + CROP_WIDTH)) &&
              (COL_W'(s0_item.line) < COL_W'(CROP_HEIGHT));
    at_end  = (cx_full == COL_W'(CROP_WIDTH - 1)) &&
              (COL_W'(s0_item.line) == COL_W'(CROP_HEIGHT - 1));
  end

  rclbo_edge_detect u_edge_detect (
    .geom   (geom),
    .active (active),
    .cx     (cx_full[CX_W-1:0]),
    .cy     (CY_W'(s0_item.line)),
    .hit    (hit)
  );

  // luma, edge flag and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s0_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_item.gray        <= hit ? EDGE_VALUE : luma(s0_item.pixel);
      out_item.crop_column <= cx_full[8:0];
      out_item.crop_line   <= s0_item.line;
      out_item.frame_end   <= at_end;
    end
  end

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output side accepts");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s0_valid))
    else $error("result appeared without a pending item");

  a_frame_end_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.frame_end) |->
      (out_item.crop_line == 9'(CROP_HEIGHT - 1)) &&
      (out_item.crop_column == 9'(CROP_WIDTH - 1)))
    else $error("frame end flagged away from the last crop pixel");

endmodule

// ===== sim/tb_rgb565_crop_luma_box_overlay_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb565_crop_luma_box_overlay_core
// Self-checking bench for the cropped luma and box-border pixel core.
// A directed table covers the color extremes, the crop limits, the last crop
// pixel and the box border cases (negative, clamped, reversed and off-crop
// edges, saturated box count). Random pixels follow in three phases with
// fresh box sets and different sender and receiver idle rates, including a
// long output stall. Every output transfer is compared field by field with
// its table entry or a local model of the luma and border logic.
// ----------------------------------------------------------------------------
module tb_rgb565_crop_luma_box_overlay_core;
  import rclbo_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 5;
  localparam int LIMIT_CYCLES   = 200000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RAND_PER_PHASE = 250;
  localparam int HOLD_CYCLES    = 90;
  localparam int MAX_REPORTS    = 10;
  localparam int DIR_ROWS       = 25;
  localparam int BOX_ROW        = 12;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

  typedef struct {
    in_item_t  px;
    bit        known;
    bit        hit;
    out_item_t want;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_item = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_item;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic [2:0]  boxes_on;
  logic [63:0] box_word [MAX_BOXES];
  out_item_t   pending [$];
  int          bad_results = 0;
  int          cycle_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{16'h0000, 10'd80,  9'd0},   1'b1, 1'b1, '{8'd0,   9'd0,   9'd0,   1'b0}},
    '{'{16'hFFFF, 10'd559, 9'd479}, 1'b1, 1'b1, '{8'd250, 9'd479, 9'd479, 1'b1}},
    '{'{16'hF800, 10'd81,  9'd1},   1'b1, 1'b1, '{8'd74,  9'd1,   9'd1,   1'b0}},
    '{'{16'h07E0, 10'd82,  9'd2},   1'b1, 1'b1, '{8'd147, 9'd2,   9'd2,   1'b0}},
    '{'{16'h001F, 10'd83,  9'd3},   1'b1, 1'b1, '{8'd28,  9'd3,   9'd3,   1'b0}},
    '{'{16'hFFFF, 10'd79,  9'd10},  1'b1, 1'b0, '0},
    '{'{16'hFFFF, 10'd560, 9'd10},  1'b1, 1'b0, '0},
    '{'{16'hFFFF, 10'd1023, 9'd511}, 1'b1, 1'b0, '0},
    '{'{16'h1234, 10'd100, 9'd480}, 1'b1, 1'b0, '0},
    '{'{16'hAAAA, 10'd639, 9'd0},   1'b1, 1'b0, '0},
    '{'{16'h5555, 10'd558, 9'd479}, 1'b0, 1'b0, '0},
    '{'{16'h8410, 10'd559, 9'd478}, 1'b0, 1'b0, '0},
    '{'{16'h1111, 10'd105, 9'd40},  1'b0, 1'b0, '0},
    '{'{16'h2222, 10'd107, 9'd40},  1'b0, 1'b0, '0},
    '{'{16'h3333, 10'd108, 9'd40},  1'b0, 1'b0, '0},
    '{'{16'h4444, 10'd130, 9'd75},  1'b0, 1'b0, '0},
    '{'{16'h5555, 10'd130, 9'd72},  1'b0, 1'b0, '0},
    '{'{16'h6666, 10'd82,  9'd5},   1'b0, 1'b0, '0},
    '{'{16'h7777, 10'd85,  9'd0},   1'b0, 1'b0, '0},
    '{'{16'h8888, 10'd559, 9'd51},  1'b0, 1'b0, '0},
    '{'{16'h9999, 10'd305, 9'd250}, 1'b0, 1'b0, '0},
    '{'{16'hAAAA, 10'd280, 9'd260}, 1'b0, 1'b0, '0},
    '{'{16'hBBBB, 10'd340, 9'd476}, 1'b0, 1'b0, '0},
    '{'{16'hCCCC, 10'd379, 9'd479}, 1'b0, 1'b0, '0},
    '{'{16'hDDDD, 10'd330, 9'd478}, 1'b0, 1'b0, '0}
  };

  rgb565_crop_luma_box_overlay_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int scale16(logic [15:0] v);
    int s;
    s = $signed(v);
    return (s * 5) / 2;
  endfunction

  function automatic int clip(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [63:0] pack_box(int x, int y, int w, int h);
    return {h[15:0], w[15:0], y[15:0], x[15:0]};
  endfunction

  function automatic bit on_border(logic [63:0] wd, int cx, int cy);
    int x, y, w, h, t;
    bit hs, vs;
    x = scale16(wd[15:0]);
    y = scale16(wd[31:16]);
    w = scale16(wd[47:32]);
    h = scale16(wd[63:48]);
    hs = (clip(x, CROP_WIDTH - 1) <= cx) && (cx <= clip(x + w, CROP_WIDTH - 1));
    vs = (clip(y, CROP_HEIGHT - 1) <= cy) && (cy <= clip(y + h, CROP_HEIGHT - 1));
    for (t = 0; t < EDGE_THICKNESS; t++) begin
      if (hs && (cy == y + t || cy == y + h - t)) return 1'b1;
      if (vs && (cx == x + t || cx == x + w - t)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // luma of one pixel with box borders, 0 when the pixel is cropped away
  function automatic bit shade_pixel(in_item_t px, output out_item_t res);
    int cx, cy, r, g, b, lum, n, i;
    res = '0;
    if (px.column >= FRAME_WIDTH || px.column < CROP_OFFSET ||
        px.column >= CROP_OFFSET + CROP_WIDTH || px.line >= CROP_HEIGHT) begin
      return 1'b0;
    end
    cx = int'(px.column) - CROP_OFFSET;
    cy = int'(px.line);
    r = int'(px.pixel[15:11]) * 8;
    g = int'(px.pixel[10:5]) * 4;
    b = int'(px.pixel[4:0]) * 8;
    lum = (299 * r + 587 * g + 114 * b) / 1000;
    n = (boxes_on > MAX_BOXES) ? MAX_BOXES : int'(boxes_on);
    for (i = 0; i < n; i++) begin
      if (on_border(box_word[i], cx, cy)) begin
        lum = 255;
        break;
      end
    end
    res.gray = lum[7:0];
    res.crop_column = cx[8:0];
    res.crop_line = cy[8:0];
    res.frame_end = (cx == CROP_WIDTH - 1) && (cy == CROP_HEIGHT - 1);
    return 1'b1;
  endfunction

  function automatic logic [63:0] rand_box();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return {$urandom, $urandom};
    if (sel == 1) return '1;
    if (sel == 2) return '0;
    return pack_box($urandom_range(0, 220) - 30, $urandom_range(0, 220) - 30,
                    $urandom_range(0, 140) - 20, $urandom_range(0, 140) - 20);
  endfunction

  // mostly crop pixels, many close to a live box border, some noise
  function automatic in_item_t pick_pixel();
    in_item_t px;
    int sel, n, k, x, y, w, h, cx, cy, lo, hi;
    px.pixel = $urandom;
    px.column = $urandom_range(0, 1023);
    px.line = $urandom_range(0, 511);
    sel = $urandom_range(0, 19);
    n = (boxes_on > MAX_BOXES) ? MAX_BOXES : int'(boxes_on);
    if (sel < 3) return px;
    if (sel == 3) begin
      px.column = CROP_OFFSET + CROP_WIDTH - 1 - $urandom_range(0, 1);
      px.line = CROP_HEIGHT - 1 - $urandom_range(0, 1);
      return px;
    end
    px.column = CROP_OFFSET + $urandom_range(0, CROP_WIDTH - 1);
    px.line = $urandom_range(0, CROP_HEIGHT - 1);
    if (sel < 10 || n == 0) return px;
    k = $urandom_range(0, n - 1);
    x = scale16(box_word[k][15:0]);
    y = scale16(box_word[k][31:16]);
    w = scale16(box_word[k][47:32]);
    h = scale16(box_word[k][63:48]);
    if ($urandom_range(0, 1)) begin
      cx = ($urandom_range(0, 1) ? x : x + w) + $urandom_range(0, 6) - 3;
      lo = (h < 0) ? y + h : y;
      hi = (h < 0) ? y : y + h;
      cy = lo - 2 + $urandom_range(0, hi - lo + 4);
    end else begin
      cy = ($urandom_range(0, 1) ? y : y + h) + $urandom_range(0, 6) - 3;
      lo = (w < 0) ? x + w : x;
      hi = (w < 0) ? x : x + w;
      cx = lo - 2 + $urandom_range(0, hi - lo + 4);
    end
    if (cx >= 0 && cx < CROP_WIDTH && cy >= 0 && cy < CROP_HEIGHT) begin
      px.column = cx + CROP_OFFSET;
      px.line = cy;
    end
    return px;
  endfunction

  task automatic send_pixel(input in_item_t px);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = px;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BOX_COUNT) begin
      boxes_on = val[2:0];
    end else if (idx >= REG_BOX_A && idx < REG_BOX_A + MAX_BOXES) begin
      box_word[idx - REG_BOX_A] = val;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // input quiet, every expected pixel out, pipeline flushed of cropped pixels
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic settle();
    repeat (2) @(posedge clk);
  endtask

  // output transfer check
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        bad_results++;
        if (bad_results <= MAX_REPORTS) begin
          $display("unexpected output transfer: gray %0d col %0d line %0d end %0d",
                   out_item.gray, out_item.crop_column, out_item.crop_line,
                   out_item.frame_end);
        end
      end else begin
        want = pending.pop_front();
        if (out_item.gray !== want.gray || out_item.crop_column !== want.crop_column ||
            out_item.crop_line !== want.crop_line || out_item.frame_end !== want.frame_end) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS) begin
            $display("mismatch: exp gray %0d col %0d line %0d end %0d, got %0d %0d %0d %0d",
                     want.gray, want.crop_column, want.crop_line, want.frame_end,
                     out_item.gray, out_item.crop_column, out_item.crop_line,
                     out_item.frame_end);
          end
        end
      end
    end
  end

  // receiver side: random stalls plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("rgb565_crop_luma_box_overlay_core verification failed");
    $finish;
  end

  initial begin
    in_item_t  px;
    out_item_t res;
    int i, ph, k;
    boxes_on = '0;
    for (i = 0; i < MAX_BOXES; i++) box_word[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table, boxes loaded halfway
    for (i = 0; i < DIR_ROWS; i++) begin
      if (i == BOX_ROW) begin
        drain();
        write_reg(REG_BOX_COUNT, 64'd7);
        write_reg(REG_BOX_A + 3'd0, pack_box(10, 10, 20, 20));
        write_reg(REG_BOX_A + 3'd1, pack_box(-3, -3, 5, 5));
        write_reg(REG_BOX_A + 3'd2, pack_box(200, 20, 10, 10));
        write_reg(REG_BOX_A + 3'd3, pack_box(100, 100, -20, 10));
        write_reg(REG_BOX_A + 3'd4, pack_box(32767, -32768, 32767, -32768));
        write_reg(REG_BOX_A + 3'd5, pack_box(100, 190, 20, 20));
        write_reg(REG_SPARE, '1);
        settle();
      end
      send_pixel(dir_rows[i].px);
      if (dir_rows[i].known) begin
        if (dir_rows[i].hit) pending.push_back(dir_rows[i].want);
      end else if (shade_pixel(dir_rows[i].px, res)) begin
        pending.push_back(res);
      end
    end

    // random phases with new box sets
    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 47 : 0;
      recv_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 21 : 0;
      drain();
      write_reg(REG_BOX_COUNT, (ph == 0) ? 64'd6 : (ph == 1) ? 64'd7 :
                64'($urandom_range(0, 7)));
      for (k = 0; k < MAX_BOXES; k++) write_reg(REG_BOX_A + k[2:0], rand_box());
      write_reg(REG_SPARE, {$urandom, $urandom});
      settle();
      for (k = 0; k < RAND_PER_PHASE; k++) begin
        if (ph == 2 && k == 60) hold_req = 1'b1;
        px = pick_pixel();
        send_pixel(px);
        if (shade_pixel(px, res)) pending.push_back(res);
      end
    end

    drain();
    bad_results += pending.size();
    if (bad_results == 0) begin
      $display("rgb565_crop_luma_box_overlay_core verification clean");
    end else begin
      $display("rgb565_crop_luma_box_overlay_core verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rclbo_pkg.sv
hw/rtl/rclbo_box_regs.sv
hw/rtl/rclbo_edge_detect.sv
hw/rtl/rgb565_crop_luma_box_overlay_core.sv
sim/tb_rgb565_crop_luma_box_overlay_core.sv
